>>> rtl/sdg_pkg.sv
`timescale 1ns / 1ps

package sdg_pkg;

  // Quotient and root width (values up to 2^30), divider remainder width,
  // root remainder width and radicand width.
  localparam int QW   = 31;
  localparam int DW   = 37;
  localparam int RW   = 35;
  localparam int RADW = 62;

  localparam logic [32:0]    ONE_S = 33'h1_0000_000;  // 1.0 in Q5.28
  localparam logic [QW-1:0]  ONE_D = 31'h4000_0000;   // 1.0 in Q1.30

  typedef enum logic [1:0] {
    KIND_GAIN         = 2'd0,
    KIND_LOAD_SHARPEN = 2'd1,
    KIND_LOAD_HALO    = 2'd2
  } kind_t;

  localparam logic [2:0] REG_LOW_NOISE   = 3'd0;
  localparam logic [2:0] REG_HIGH_NOISE  = 3'd1;
  localparam logic [2:0] REG_HALO        = 3'd2;
  localparam logic [2:0] REG_SHARPEN_STR = 3'd3;
  localparam logic [2:0] REG_DEHALO_STR  = 3'd4;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] nq;
    logic [DW-1:0] dvs;
  } div_lane_t;

  typedef struct packed {
    logic      valid;
    div_lane_t f1;
    div_lane_t f2;
    div_lane_t dd;
    logic [31:0] t;
    logic      se;
    logic      zs;
    logic      de;
    logic      zd;
  } div_stage_t;

  typedef struct packed {
    logic            valid;
    logic [RW-1:0]   rem;
    logic [QW-1:0]   root;
    logic [RADW-1:0] rad;
    logic [31:0]     t;
    logic [QW-1:0]   d;
    logic            sa;
    logic            ovf;
  } sqrt_stage_t;

endpackage

>>> rtl/sdg_div_cell.sv
`timescale 1ns / 1ps

module sdg_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  sdg_pkg::div_stage_t din,
  output sdg_pkg::div_stage_t dout
);

  // One restoring quotient bit per lane.
  function automatic sdg_pkg::div_lane_t lane_step(sdg_pkg::div_lane_t x);
    logic [sdg_pkg::DW:0] sh;
    logic                 ge;
    sdg_pkg::div_lane_t   y;
    sh     = {x.rem, x.nq[sdg_pkg::QW-1]};
    ge     = sh >= {1'b0, x.dvs};
    y.dvs  = x.dvs;
    y.rem  = ge ? sdg_pkg::DW'(sh - {1'b0, x.dvs}) : sdg_pkg::DW'(sh);
    y.nq   = {x.nq[sdg_pkg::QW-2:0], ge};
    return y;
  endfunction

  sdg_pkg::div_stage_t nxt;

  always_comb begin
    nxt    = din;
    nxt.f1 = lane_step(din.f1);
    nxt.f2 = lane_step(din.f2);
    nxt.dd = lane_step(din.dd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

`ifndef ASSERT_OFF
  a_f1_rem: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.f1.dvs != '0 |-> dout.f1.rem < dout.f1.dvs)
    else $error("f1 remainder not below divisor");
  a_f2_rem: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.f2.dvs != '0 |-> dout.f2.rem < dout.f2.dvs)
    else $error("f2 remainder not below divisor");
  a_dd_rem: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.dd.dvs != '0 |-> dout.dd.rem < dout.dd.dvs)
    else $error("dehalo remainder not below divisor");
`endif

endmodule

>>> rtl/sdg_sqrt_cell.sv
`timescale 1ns / 1ps

module sdg_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  sdg_pkg::sqrt_stage_t din,
  output sdg_pkg::sqrt_stage_t dout
);

  logic [sdg_pkg::RW-1:0] sh;
  logic [sdg_pkg::RW-1:0] trial;
  logic                   ge;
  sdg_pkg::sqrt_stage_t   nxt;

  // One root bit per cell: bring in two radicand bits, try 4*root+1.
  always_comb begin
    sh       = {din.rem[sdg_pkg::RW-3:0], din.rad[sdg_pkg::RADW-1 -: 2]};
    trial    = sdg_pkg::RW'({din.root, 2'b01});
    ge       = sh >= trial;
    nxt      = din;
    nxt.rem  = ge ? sh - trial : sh;
    nxt.root = {din.root[sdg_pkg::QW-2:0], ge};
    nxt.rad  = {din.rad[sdg_pkg::RADW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.rem <= sdg_pkg::RW'({dout.root, 1'b0}))
    else $error("root remainder exceeds twice the partial root");
`endif

endmodule

>>> rtl/spectral_sharpen_dehalo_gain_top.sv
`timescale 1ns / 1ps

// Spectral sharpen and dehalo gain.
// Input channel (in_valid / in_stall): one bin per transfer. A gain item
// returns one result; a load item writes one window table entry and
// returns nothing. Output channel (out_valid / out_stall) carries gain and
// overflow. The user writes the configuration port (cfg_write, cfg_index,
// cfg_data) only while no gain item is in flight; the block does not
// enforce this. Throughput is one transfer per cycle unless the output
// stalls. A result passes three prep stages (table read, two multiplies),
// 31 divider cells (one quotient bit each, three lanes), a multiply stage,
// 31 square root cells (one root bit each), a multiply stage, an add stage
// and the output register. All stages advance together, so while a result
// waits in the output register under stall, the whole chain and the input
// hold. Reset clears the configuration registers and every valid bit; the
// window tables hold nothing defined until written. A load takes effect
// for any gain item transferred in a later cycle.

module spectral_sharpen_dehalo_gain_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [9:0]  bin_index,
  input  logic [31:0] power,
  input  logic [15:0] window_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] gain,
  output logic        overflow
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Configuration registers.
  logic [31:0] low_noise_term;
  logic [31:0] high_noise_term;
  logic [31:0] halo_term;
  logic [15:0] sharpen_strength;
  logic [15:0] dehalo_strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_noise_term   <= '0;
      high_noise_term  <= '0;
      halo_term        <= '0;
      sharpen_strength <= '0;
      dehalo_strength  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sdg_pkg::REG_LOW_NOISE:   low_noise_term   <= cfg_data;
        sdg_pkg::REG_HIGH_NOISE:  high_noise_term  <= cfg_data;
        sdg_pkg::REG_HALO:        halo_term        <= cfg_data;
        sdg_pkg::REG_SHARPEN_STR: sharpen_strength <= cfg_data[15:0];
        sdg_pkg::REG_DEHALO_STR:  dehalo_strength  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The whole chain moves when the output register is free or being taken.
  logic en;
  logic accept;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  logic [16:0]   idx;
  logic          inr;
  logic [AW-1:0] addr;
  assign idx  = 17'(bin_index);
  assign inr  = idx < 17'(TABLE_DEPTH);
  assign addr = idx[AW-1:0];

  // Window tables, written by load transfers and read with a registered port.
  logic [15:0] sharpen_mem [TABLE_DEPTH];
  logic [15:0] halo_mem    [TABLE_DEPTH];
  logic [15:0] ws_rd;
  logic [15:0] wh_rd;

  always_ff @(posedge clk) begin
    if (accept && inr && kind == sdg_pkg::KIND_LOAD_SHARPEN) begin
      sharpen_mem[addr] <= window_value;
    end
    if (accept && inr && kind == sdg_pkg::KIND_LOAD_HALO) begin
      halo_mem[addr] <= window_value;
    end
    if (en) begin
      ws_rd <= sharpen_mem[addr];
      wh_rd <= halo_mem[addr];
    end
  end

  // Stage A: capture the bin while the tables are read.
  logic        a_valid;
  logic [31:0] a_q;
  logic        a_inr;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= accept && kind == sdg_pkg::KIND_GAIN;
    end
    if (en) begin
      a_q   <= power;
      a_inr <= inr;
    end
  end

  // Stage B: strength times window, Q4.28. An index past the table reads zero.
  logic        b_valid;
  logic [31:0] b_q;
  logic [31:0] b_t;
  logic [31:0] b_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_q <= a_q;
      b_t <= 32'(sharpen_strength) * 32'(a_inr ? ws_rd : 16'd0);
      b_h <= 32'(dehalo_strength) * 32'(a_inr ? wh_rd : 16'd0);
    end
  end

  // Stage C: halo term h*q in Q16.16 and the three sums.
  logic        c_valid;
  logic [31:0] c_q;
  logic [31:0] c_t;
  logic [35:0] c_hq;
  logic [32:0] c_qa;
  logic [32:0] c_qb;
  logic [32:0] c_qc;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_q  <= b_q;
      c_t  <= b_t;
      c_hq <= 36'((64'(b_h) * 64'(b_q)) >> 28);
      c_qa <= 33'(b_q) + 33'(low_noise_term);
      c_qb <= 33'(b_q) + 33'(high_noise_term);
      c_qc <= 33'(b_q) + 33'(halo_term);
    end
  end

  // Divider setup. Each numerator is x*2^30 and its quotient stays below
  // 2^31, so the top bits start as the remainder and the low 31 bits
  // are shifted in one per cell.
  logic [sdg_pkg::DW-1:0] den;
  sdg_pkg::div_stage_t    ds [sdg_pkg::QW+1];

  assign den = sdg_pkg::DW'(c_qc) + sdg_pkg::DW'(c_hq);

  always_comb begin
    ds[0].valid  = c_valid;
    ds[0].f1.rem = sdg_pkg::DW'(c_q >> 1);
    ds[0].f1.nq  = {c_q[0], {(sdg_pkg::QW-1){1'b0}}};
    ds[0].f1.dvs = sdg_pkg::DW'(c_qa);
    ds[0].f2.rem = sdg_pkg::DW'(high_noise_term >> 1);
    ds[0].f2.nq  = {high_noise_term[0], {(sdg_pkg::QW-1){1'b0}}};
    ds[0].f2.dvs = sdg_pkg::DW'(c_qb);
    ds[0].dd.rem = sdg_pkg::DW'(c_qc >> 1);
    ds[0].dd.nq  = {c_qc[0], {(sdg_pkg::QW-1){1'b0}}};
    ds[0].dd.dvs = den;
    ds[0].t      = c_t;
    ds[0].se     = sharpen_strength != '0 && high_noise_term != '0;
    ds[0].zs     = c_qa == '0;
    ds[0].de     = dehalo_strength != '0;
    ds[0].zd     = den == '0;
  end

  for (genvar i = 0; i < sdg_pkg::QW; i++) begin : g_div
    sdg_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (ds[i]),
      .dout (ds[i+1])
    );
  end

  // Stage P: radicand f1*f2 and the dehalo factor. A zero-over-zero factor
  // is taken as one and flagged.
  sdg_pkg::sqrt_stage_t ss [sdg_pkg::QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ss[0].valid <= 1'b0;
    end else if (en) begin
      ss[0].valid <= ds[sdg_pkg::QW].valid;
    end
    if (en) begin
      ss[0].rem  <= '0;
      ss[0].root <= '0;
      ss[0].rad  <= sdg_pkg::RADW'(ds[sdg_pkg::QW].f1.nq) *
                    sdg_pkg::RADW'(ds[sdg_pkg::QW].f2.nq);
      ss[0].t    <= ds[sdg_pkg::QW].t;
      ss[0].d    <= (ds[sdg_pkg::QW].de && !ds[sdg_pkg::QW].zd) ?
                    ds[sdg_pkg::QW].dd.nq : sdg_pkg::ONE_D;
      ss[0].sa   <= ds[sdg_pkg::QW].se && !ds[sdg_pkg::QW].zs;
      ss[0].ovf  <= (ds[sdg_pkg::QW].se && ds[sdg_pkg::QW].zs) ||
                    (ds[sdg_pkg::QW].de && ds[sdg_pkg::QW].zd);
    end
  end

  for (genvar i = 0; i < sdg_pkg::QW; i++) begin : g_sqrt
    sdg_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (ss[i]),
      .dout (ss[i+1])
    );
  end

  // Stage M: t times root. Stage N: sharpen factor in Q5.28.
  logic                   m_valid;
  logic [62:0]            m_tr;
  logic                   m_sa;
  logic                   m_ovf;
  logic [sdg_pkg::QW-1:0] m_d;
  logic                   n_valid;
  logic [32:0]            n_s;
  logic                   n_ovf;
  logic [sdg_pkg::QW-1:0] n_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      n_valid <= 1'b0;
    end else if (en) begin
      m_valid <= ss[sdg_pkg::QW].valid;
      n_valid <= m_valid;
    end
    if (en) begin
      m_tr  <= 63'(ss[sdg_pkg::QW].t) * 63'(ss[sdg_pkg::QW].root);
      m_sa  <= ss[sdg_pkg::QW].sa;
      m_ovf <= ss[sdg_pkg::QW].ovf;
      m_d   <= ss[sdg_pkg::QW].d;
      n_s   <= m_sa ? sdg_pkg::ONE_S + 33'(m_tr >> 30) : sdg_pkg::ONE_S;
      n_ovf <= m_ovf;
      n_d   <= m_d;
    end
  end

  // Output register. s is below 17 and d at most 1, so the top 18 bits of
  // s*d already are the gain and it never needs clamping.
  logic [63:0] sd;
  assign sd = 64'(n_s) * 64'(n_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= n_valid;
    end
    if (en) begin
      gain     <= sd[63:46];
      overflow <= n_ovf;
    end
  end

endmodule
